// File: hw/rtl/tcte_pkg.sv
// Shared types, codes, wave table and saturation helpers for the channel tick effects core.
`default_nettype none

package tcte_pkg;

  typedef enum logic [3:0] {
    KIND_LOAD      = 4'd0,
    KIND_TARGET    = 4'd1,
    KIND_TONEPORTA = 4'd2,
    KIND_UP        = 4'd3,
    KIND_DOWN      = 4'd4,
    KIND_VOLSLIDE  = 4'd5,
    KIND_VIBRATO   = 4'd6,
    KIND_TREMOLO   = 4'd7,
    KIND_TREMOR    = 4'd8,
    KIND_PANSLIDE  = 4'd9,
    KIND_EXTENDED  = 4'd10,
    KIND_XFINE     = 4'd11,
    KIND_SETVOL    = 4'd12,
    KIND_SETPAN    = 4'd13
  } kind_t;

  // extended / xfine sub-commands (high nibble of param)
  localparam logic [3:0] EXT_FINE_UP       = 4'h1;
  localparam logic [3:0] EXT_FINE_DOWN     = 4'h2;
  localparam logic [3:0] EXT_VIB_MODE      = 4'h4;
  localparam logic [3:0] EXT_TREM_MODE     = 4'h7;
  localparam logic [3:0] EXT_FINE_VOL_UP   = 4'hA;
  localparam logic [3:0] EXT_FINE_VOL_DOWN = 4'hB;

  // remembered full-byte parameters
  localparam logic [2:0] SLOT_UP       = 3'd0;
  localparam logic [2:0] SLOT_DOWN     = 3'd1;
  localparam logic [2:0] SLOT_VOLSLIDE = 3'd2;
  localparam logic [2:0] SLOT_PANSLIDE = 3'd3;
  localparam logic [2:0] SLOT_TREMOR   = 3'd4;
  localparam int unsigned FULL_SLOTS   = 5;

  // remembered fine-slide nibbles
  localparam logic [1:0] FSLOT_UP       = 2'd0;
  localparam logic [1:0] FSLOT_DOWN     = 2'd1;
  localparam logic [1:0] FSLOT_VOL_UP   = 2'd2;
  localparam logic [1:0] FSLOT_VOL_DOWN = 2'd3;
  localparam int unsigned FINE_SLOTS    = 4;

  localparam logic [1:0] WAVE_SINE   = 2'd0;
  localparam logic [1:0] WAVE_RAMP   = 2'd1;
  localparam logic [1:0] WAVE_SQUARE = 2'd2;
  localparam logic [1:0] WAVE_INDEX  = 2'd3;

  localparam logic [14:0] PERIOD_MAX = 15'h7cff;
  localparam logic [6:0]  VOLUME_MAX = 7'h40;

  localparam logic [7:0] WAVE_TABLE [32] = '{
    8'd0,   8'd24,  8'd49,  8'd74,  8'd97,  8'd120, 8'd141, 8'd161,
    8'd180, 8'd197, 8'd212, 8'd224, 8'd235, 8'd244, 8'd250, 8'd253,
    8'd255, 8'd253, 8'd250, 8'd244, 8'd235, 8'd224, 8'd212, 8'd197,
    8'd180, 8'd161, 8'd141, 8'd120, 8'd97,  8'd74,  8'd49,  8'd24
  };

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  param;
    logic [14:0] period_value;
    logic [6:0]  volume_value;
  } item_t;

  typedef struct packed {
    logic [14:0] out_period;
    logic [6:0]  out_volume;
    logic [7:0]  out_pan;
  } result_t;

  typedef struct packed {
    logic [7:0] phase;
    logic [1:0] mode;
    logic [3:0] depth;
    logic       ramp_up;   // vib_phase bit 7, shared by both ramps
  } osc_req_t;

  function automatic logic [14:0] clamp_period(input logic signed [17:0] v);
    logic [14:0] r;
    if (v < 18'sd1) r = 15'd1;
    else if (v > $signed({3'b000, PERIOD_MAX})) r = PERIOD_MAX;
    else r = v[14:0];
    return r;
  endfunction

  function automatic logic [6:0] clamp_volume(input logic signed [9:0] v);
    logic [6:0] r;
    if (v < 10'sd0) r = 7'd0;
    else if (v > $signed({3'b000, VOLUME_MAX})) r = VOLUME_MAX;
    else r = v[6:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tcte_osc.sv
// Vibrato/tremolo oscillator: wave lookup scaled by depth.
`default_nettype none

module tcte_osc (
  input  tcte_pkg::osc_req_t req,
  output logic [11:0]        prod
);

  logic [4:0] idx;
  logic [7:0] wave;

  assign idx = req.phase[6:2];

  always_comb begin
    case (req.mode)
      tcte_pkg::WAVE_SINE:   wave = tcte_pkg::WAVE_TABLE[idx];
      tcte_pkg::WAVE_RAMP:   wave = req.ramp_up ? {idx, 3'b000} : ~{idx, 3'b000};
      tcte_pkg::WAVE_SQUARE: wave = 8'hff;
      default:               wave = {3'b000, idx};
    endcase
  end

  assign prod = {4'b0000, wave} * {8'b0, req.depth};

endmodule

`default_nettype wire

// File: hw/rtl/tcte_engine.sv
// Channel state registers and combinational effect update.
`default_nettype none

module tcte_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  tcte_pkg::item_t     item,
  output tcte_pkg::result_t   res
);

  logic [14:0] base_period, current_period, target_period;
  logic [6:0]  base_volume, current_volume;
  logic [7:0]  pan_position;
  logic [9:0]  slide_speed;
  logic [7:0]  vib_phase, trem_phase;
  logic [5:0]  vib_speed, trem_speed;
  logic [3:0]  vib_depth, trem_depth, vib_mode, trem_mode;
  logic [7:0]  gate_countdown;
  logic [7:0]  last_full [tcte_pkg::FULL_SLOTS];
  logic [3:0]  last_fine [tcte_pkg::FINE_SLOTS];

  logic [14:0] base_period_next, current_period_next, target_period_next;
  logic [6:0]  base_volume_next, current_volume_next;
  logic [7:0]  pan_position_next;
  logic [9:0]  slide_speed_next;
  logic [7:0]  vib_phase_next, trem_phase_next;
  logic [5:0]  vib_speed_next, trem_speed_next;
  logic [3:0]  vib_depth_next, trem_depth_next, vib_mode_next, trem_mode_next;
  logic [7:0]  gate_countdown_next;

  logic [3:0]  hi, lo;
  logic [2:0]  full_slot;
  logic        full_used;
  logic [7:0]  rp;
  logic [1:0]  fine_slot;
  logic        fine_used;
  logic [3:0]  rn;

  tcte_pkg::osc_req_t osc_req;
  logic [11:0]        osc_prod;

  assign hi = item.param[7:4];
  assign lo = item.param[3:0];

  // which remembered parameter this command uses
  always_comb begin
    full_used = 1'b1;
    case (item.kind)
      tcte_pkg::KIND_UP:       full_slot = tcte_pkg::SLOT_UP;
      tcte_pkg::KIND_DOWN:     full_slot = tcte_pkg::SLOT_DOWN;
      tcte_pkg::KIND_VOLSLIDE: full_slot = tcte_pkg::SLOT_VOLSLIDE;
      tcte_pkg::KIND_PANSLIDE: full_slot = tcte_pkg::SLOT_PANSLIDE;
      tcte_pkg::KIND_TREMOR:   full_slot = tcte_pkg::SLOT_TREMOR;
      default: begin
        full_slot = tcte_pkg::SLOT_UP;
        full_used = 1'b0;
      end
    endcase
  end

  always_comb begin
    fine_used = 1'b0;
    fine_slot = tcte_pkg::FSLOT_UP;
    if (item.kind == tcte_pkg::KIND_EXTENDED || item.kind == tcte_pkg::KIND_XFINE) begin
      case (hi)
        tcte_pkg::EXT_FINE_UP: begin
          fine_used = 1'b1;
          fine_slot = tcte_pkg::FSLOT_UP;
        end
        tcte_pkg::EXT_FINE_DOWN: begin
          fine_used = 1'b1;
          fine_slot = tcte_pkg::FSLOT_DOWN;
        end
        tcte_pkg::EXT_FINE_VOL_UP: begin
          fine_used = (item.kind == tcte_pkg::KIND_EXTENDED);
          fine_slot = tcte_pkg::FSLOT_VOL_UP;
        end
        tcte_pkg::EXT_FINE_VOL_DOWN: begin
          fine_used = (item.kind == tcte_pkg::KIND_EXTENDED);
          fine_slot = tcte_pkg::FSLOT_VOL_DOWN;
        end
        default: fine_used = 1'b0;
      endcase
    end
  end

  assign rp = (item.param != 8'd0) ? item.param : last_full[full_slot];
  assign rn = (lo != 4'd0) ? lo : last_fine[fine_slot];

  always_comb begin
    osc_req.phase   = (item.kind == tcte_pkg::KIND_TREMOLO) ? trem_phase : vib_phase;
    osc_req.mode    = (item.kind == tcte_pkg::KIND_TREMOLO) ? trem_mode[1:0] : vib_mode[1:0];
    osc_req.ramp_up = vib_phase[7];
    if (item.kind == tcte_pkg::KIND_TREMOLO) osc_req.depth = (lo != 4'd0) ? lo : trem_depth;
    else osc_req.depth = (lo != 4'd0) ? lo : vib_depth;
  end

  tcte_osc u_osc (
    .req  (osc_req),
    .prod (osc_prod)
  );

  always_comb begin
    logic signed [17:0] bp, tp, r;
    logic signed [9:0]  bv, pt;
    logic [14:0]        p_sat;
    logic [6:0]         v_sat;

    base_period_next    = base_period;
    current_period_next = current_period;
    target_period_next  = target_period;
    base_volume_next    = base_volume;
    current_volume_next = current_volume;
    pan_position_next   = pan_position;
    slide_speed_next    = slide_speed;
    vib_phase_next      = vib_phase;
    vib_speed_next      = vib_speed;
    vib_depth_next      = vib_depth;
    vib_mode_next       = vib_mode;
    trem_phase_next     = trem_phase;
    trem_speed_next     = trem_speed;
    trem_depth_next     = trem_depth;
    trem_mode_next      = trem_mode;
    gate_countdown_next = gate_countdown;

    bp    = $signed({3'b000, base_period});
    tp    = $signed({3'b000, target_period});
    bv    = $signed({3'b000, base_volume});
    r     = bp;
    pt    = $signed({2'b00, pan_position});
    p_sat = tcte_pkg::clamp_period(bp);
    v_sat = tcte_pkg::clamp_volume(bv);

    case (item.kind)
      tcte_pkg::KIND_LOAD: begin
        p_sat = tcte_pkg::clamp_period($signed({3'b000, item.period_value}));
        v_sat = tcte_pkg::clamp_volume($signed({3'b000, item.volume_value}));
        base_period_next    = p_sat;
        current_period_next = p_sat;
        base_volume_next    = v_sat;
        current_volume_next = v_sat;
        if (!vib_mode[2]) vib_phase_next = 8'd0;
        trem_phase_next     = 8'd0;
        gate_countdown_next = 8'd0;
      end
      tcte_pkg::KIND_TARGET: begin
        target_period_next = tcte_pkg::clamp_period($signed({3'b000, item.period_value}));
        if (item.param != 8'd0) slide_speed_next = {item.param, 2'b00};
      end
      tcte_pkg::KIND_TONEPORTA: begin
        if (tp != bp) begin
          if (tp < bp) begin
            r = bp - $signed({8'b0, slide_speed});
            if (r < tp) r = tp;
          end else begin
            r = bp + $signed({8'b0, slide_speed});
            if (r > tp) r = tp;
          end
          p_sat = tcte_pkg::clamp_period(r);
          base_period_next    = p_sat;
          current_period_next = p_sat;
        end
      end
      tcte_pkg::KIND_UP, tcte_pkg::KIND_DOWN: begin
        if (item.kind == tcte_pkg::KIND_UP) r = bp - $signed({8'b0, rp, 2'b00});
        else r = bp + $signed({8'b0, rp, 2'b00});
        p_sat = tcte_pkg::clamp_period(r);
        base_period_next    = p_sat;
        current_period_next = p_sat;
      end
      tcte_pkg::KIND_VOLSLIDE: begin
        if (rp[7:4] == 4'd0) v_sat = tcte_pkg::clamp_volume(bv - $signed({6'b0, rp[3:0]}));
        else v_sat = tcte_pkg::clamp_volume(bv + $signed({6'b0, rp[7:4]}));
        base_volume_next    = v_sat;
        current_volume_next = v_sat;
      end
      tcte_pkg::KIND_VIBRATO: begin
        vib_depth_next = osc_req.depth;
        if (hi != 4'd0) vib_speed_next = {hi, 2'b00};
        if (vib_phase[7]) r = bp - $signed({11'b0, osc_prod[11:5]});
        else r = bp + $signed({11'b0, osc_prod[11:5]});
        current_period_next = tcte_pkg::clamp_period(r);
        vib_phase_next = vib_phase + {2'b00, vib_speed_next};
      end
      tcte_pkg::KIND_TREMOLO: begin
        trem_depth_next = osc_req.depth;
        if (hi != 4'd0) trem_speed_next = {hi, 2'b00};
        if (trem_phase[7]) v_sat = tcte_pkg::clamp_volume(bv - $signed({4'b0, osc_prod[11:6]}));
        else v_sat = tcte_pkg::clamp_volume(bv + $signed({4'b0, osc_prod[11:6]}));
        current_volume_next = v_sat;
        trem_phase_next = trem_phase + {2'b00, trem_speed_next};
      end
      tcte_pkg::KIND_TREMOR: begin
        if (gate_countdown[6:0] == 7'd0) begin
          if (gate_countdown[7]) gate_countdown_next = {4'b0000, rp[3:0]};
          else gate_countdown_next = {4'b1000, rp[7:4]};
        end else begin
          gate_countdown_next = {gate_countdown[7], gate_countdown[6:0] - 7'd1};
        end
        current_volume_next = gate_countdown_next[7] ? base_volume : 7'd0;
      end
      tcte_pkg::KIND_PANSLIDE: begin
        if (rp[7:4] == 4'd0) pt = pt - $signed({2'b00, rp});
        else pt = pt + $signed({6'b0, rp[7:4]});
        if (pt < 10'sd0) pan_position_next = 8'd0;
        else if (pt > 10'sd255) pan_position_next = 8'hff;
        else pan_position_next = pt[7:0];
      end
      tcte_pkg::KIND_EXTENDED: begin
        case (hi)
          tcte_pkg::EXT_FINE_UP, tcte_pkg::EXT_FINE_DOWN: begin
            if (hi == tcte_pkg::EXT_FINE_UP) r = bp - $signed({12'b0, rn, 2'b00});
            else r = bp + $signed({12'b0, rn, 2'b00});
            p_sat = tcte_pkg::clamp_period(r);
            base_period_next    = p_sat;
            current_period_next = p_sat;
          end
          tcte_pkg::EXT_VIB_MODE:  vib_mode_next = lo;
          tcte_pkg::EXT_TREM_MODE: trem_mode_next = lo;
          tcte_pkg::EXT_FINE_VOL_UP, tcte_pkg::EXT_FINE_VOL_DOWN: begin
            if (hi == tcte_pkg::EXT_FINE_VOL_UP) v_sat = tcte_pkg::clamp_volume(bv + $signed({6'b0, rn}));
            else v_sat = tcte_pkg::clamp_volume(bv - $signed({6'b0, rn}));
            base_volume_next    = v_sat;
            current_volume_next = v_sat;
          end
          default: ;
        endcase
      end
      tcte_pkg::KIND_XFINE: begin
        if (hi == tcte_pkg::EXT_FINE_UP || hi == tcte_pkg::EXT_FINE_DOWN) begin
          if (hi == tcte_pkg::EXT_FINE_UP) r = bp - $signed({14'b0, rn});
          else r = bp + $signed({14'b0, rn});
          p_sat = tcte_pkg::clamp_period(r);
          base_period_next    = p_sat;
          current_period_next = p_sat;
        end
      end
      tcte_pkg::KIND_SETVOL: begin
        if (item.param <= {1'b0, tcte_pkg::VOLUME_MAX}) begin
          base_volume_next    = item.param[6:0];
          current_volume_next = item.param[6:0];
        end
      end
      tcte_pkg::KIND_SETPAN: pan_position_next = item.param;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_period    <= '0;
      current_period <= '0;
      target_period  <= '0;
      base_volume    <= '0;
      current_volume <= '0;
      pan_position   <= '0;
      slide_speed    <= '0;
      vib_phase      <= '0;
      vib_speed      <= '0;
      vib_depth      <= '0;
      vib_mode       <= '0;
      trem_phase     <= '0;
      trem_speed     <= '0;
      trem_depth     <= '0;
      trem_mode      <= '0;
      gate_countdown <= '0;
      for (int i = 0; i < tcte_pkg::FULL_SLOTS; i++) last_full[i] <= '0;
      for (int i = 0; i < tcte_pkg::FINE_SLOTS; i++) last_fine[i] <= '0;
    end else if (fire) begin
      base_period    <= base_period_next;
      current_period <= current_period_next;
      target_period  <= target_period_next;
      base_volume    <= base_volume_next;
      current_volume <= current_volume_next;
      pan_position   <= pan_position_next;
      slide_speed    <= slide_speed_next;
      vib_phase      <= vib_phase_next;
      vib_speed      <= vib_speed_next;
      vib_depth      <= vib_depth_next;
      vib_mode       <= vib_mode_next;
      trem_phase     <= trem_phase_next;
      trem_speed     <= trem_speed_next;
      trem_depth     <= trem_depth_next;
      trem_mode      <= trem_mode_next;
      gate_countdown <= gate_countdown_next;
      if (full_used && item.param != 8'd0) last_full[full_slot] <= item.param;
      if (fine_used && lo != 4'd0) last_fine[fine_slot] <= lo;
    end
  end

  assign res.out_period = current_period_next;
  assign res.out_volume = current_volume_next;
  assign res.out_pan    = pan_position_next;

endmodule

`default_nettype wire

// File: hw/rtl/tracker_channel_tick_effects_core.sv
// Top level of the channel tick effects core: stream ports, input and result registers.
`default_nettype none

// One effect command per transaction, one result per command. The core takes a
// new command every cycle while s_axis_tready is high; a command waits in the
// input register, where its whole state update (period/volume slides,
// oscillator lookup and multiply, saturation) is computed combinationally, and
// is captured into the result register when it advances, so a result passes
// through the input register and then the result register. The result register
// lets one new command in while a finished result waits for m_axis_tready; with
// both registers full s_axis_tready drops. The period registers reset to zero, so
// commands before the first load command that leave the period alone report zero.
module tracker_channel_tick_effects_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // param[7:0], period_value[22:8], volume_value[29:23]
  input  logic [3:0]  s_axis_tuser,   // kind[3:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // out_period[14:0], out_volume[21:15], out_pan[29:22]
);

  logic              in_valid;
  tcte_pkg::item_t   in_item;
  logic              out_valid;
  tcte_pkg::result_t out_res;
  tcte_pkg::result_t res;
  logic              advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (!out_valid || m_axis_tready) out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.kind         <= tcte_pkg::kind_t'(s_axis_tuser);
      in_item.param        <= s_axis_tdata[7:0];
      in_item.period_value <= s_axis_tdata[22:8];
      in_item.volume_value <= s_axis_tdata[29:23];
    end
    if (advance) out_res <= res;
  end

  tcte_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (in_item),
    .res  (res)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_res.out_pan, out_res.out_volume, out_res.out_period};

endmodule

`default_nettype wire
